// File: sv/lom_pkg.sv
// ----------------------------------------------------------------------------
// lom_pkg: shared types and constants for the order matcher
// Book entry layout and the control struct between sequencer and compare unit.
// ----------------------------------------------------------------------------
package lom_pkg;

  localparam int unsigned SlotsDefault = 32;
  localparam int unsigned IdW    = 32;
  localparam int unsigned PriceW = 24;
  localparam int unsigned QtyW   = 32;
  localparam int unsigned SeqW   = 32;
  localparam int unsigned TimeW  = 48;
  localparam int unsigned EntryW = IdW + PriceW + QtyW + SeqW;

  localparam logic KIND_TRADE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic [IdW-1:0]    owner_id;
    logic [PriceW-1:0] price;
    logic [QtyW-1:0]   qty;
    logic [SeqW-1:0]   seq;
  } entry_t;

  // control from sequencer to the compare unit
  typedef struct packed {
    logic clear;
    logic step;
    logic side;
  } cmp_ctl_t;

endpackage

// File: sv/lom_ram.sv
// ----------------------------------------------------------------------------
// lom_ram: generic simple dual-port ram
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module lom_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/lom_best.sv
// ----------------------------------------------------------------------------
// lom_best: shared compare unit for the best-slot scan
// Keeps the running best of one side, one slot per cycle while step is set.
// ----------------------------------------------------------------------------
module lom_best
  import lom_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  cmp_ctl_t                                    ctl,
  input  logic                                        cand_valid,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] cand_idx,
  input  entry_t                                      cand,
  input  logic [SeqW-1:0]                             arrival,
  output logic                                        found,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] best_idx,
  output entry_t                                      best
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic                     found_r, found_nxt;
  logic [IW-1:0]            idx_r, idx_nxt;
  entry_t                   best_r, best_nxt;
  logic                     better;
  logic [SeqW-1:0]          age_c, age_b;

  always_comb begin
    age_c  = arrival - cand.seq;
    age_b  = arrival - best_r.seq;
    better = (ctl.side == 1'b0) ? (cand.price < best_r.price)
                                : (cand.price > best_r.price);
    if (!better && cand.price == best_r.price) begin
      better = age_c > age_b;
    end
    found_nxt = found_r;
    idx_nxt   = idx_r;
    best_nxt  = best_r;
    if (ctl.clear) begin
      found_nxt = 1'b0;
    end else if (ctl.step && cand_valid && (!found_r || better)) begin
      found_nxt = 1'b1;
      idx_nxt   = cand_idx;
      best_nxt  = cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
    idx_r  <= idx_nxt;
    best_r <= best_nxt;
  end

  assign found    = found_r;
  assign best_idx = idx_r;
  assign best     = best_r;

endmodule

// File: sv/limit_order_matcher.sv
// ----------------------------------------------------------------------------
// limit_order_matcher: price-time priority order matcher
// Matches one incoming order against a stored book, emits trades and status.
// ----------------------------------------------------------------------------
// scan pass: each slot is read in turn through the shared compare unit, then a spare
// state (S_DEC), then the trade decision; an order takes one pass per fill, one more
// pass when matching ends on no match or no cross, then S_FREE, S_STAT, S_DRAIN and
// S_WAIT; the free-slot search is combinational, used in S_FREE; out_tready stalls add.
// one order at a time: in_tready is high only in the idle state.
// reset: synchronous active-low; empties the book and clears the arrival count.
module limit_order_matcher
  import lom_pkg::*;
#(
  parameter int unsigned SLOTS_PER_SIDE = SlotsDefault
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // order_id[31:0], side[32], is_limit[33], limit_price[57:34], quantity[89:58],
  // arrival_time[137:90], zeros above
  input  logic [143:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // resting_id[31:0], aggressive_id[63:32], trade_price[87:64],
  // trade_quantity[119:88], trade_time[167:120], aggressive_side[168],
  // rested[169], dropped_full[170], leftover_quantity[202:171], zeros above
  output logic [207:0] out_tdata,
  // kind
  output logic         out_tuser,
  output logic         out_tlast
);

  localparam int unsigned IW = (SLOTS_PER_SIDE > 1) ? $clog2(SLOTS_PER_SIDE) : 1;
  localparam int unsigned AW = IW + 1;
  localparam int unsigned BD = 1 << AW;
  localparam int unsigned CW = $clog2(SLOTS_PER_SIDE + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCAN  = 8'b0000_0010,
    S_DEC   = 8'b0000_0100,
    S_TRADE = 8'b0000_1000,
    S_FREE  = 8'b0001_0000,
    S_STAT  = 8'b0010_0000,
    S_DRAIN = 8'b0100_0000,
    S_WAIT  = 8'b1000_0000
  } state_t;

  state_t               st_r, st_nxt;
  logic [BD-1:0]        vld_r, vld_nxt;
  logic [SeqW-1:0]      arr_r, arr_nxt;
  logic [IdW-1:0]       id_r, id_nxt;
  logic                 side_r, side_nxt, lim_r, lim_nxt;
  logic [PriceW-1:0]    lp_r, lp_nxt;
  logic [QtyW-1:0]      qty_r, qty_nxt;
  logic [TimeW-1:0]     t_r, t_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt, n_r, n_nxt;
  logic                 sv_r, sv_nxt;          // read issued last cycle
  logic [IW-1:0]        si_r, si_nxt;          // index of that read
  logic                 ov_r, ov_nxt;
  logic [207:0]         od_r, od_nxt;
  logic                 ou_r, ou_nxt;
  logic                 rest_r, rest_nxt, drop_r, drop_nxt;

  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  entry_t               wdata, rdata;
  cmp_ctl_t             ctl;
  logic                 found;
  logic [IW-1:0]        bidx;
  entry_t               best;
  logic [QtyW-1:0]      fill;
  logic                 no_cross;
  logic [IW-1:0]        free_idx;
  logic                 free_ok;
  logic                 acc_in;

  lom_ram #(.WIDTH(EntryW), .DEPTH(BD)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  lom_best #(.SLOTS(SLOTS_PER_SIDE)) u_best (
    .clk(clk), .rst_n(rst_n), .ctl(ctl),
    .cand_valid(sv_r && vld_r[{~side_r, si_r}]),
    .cand_idx(si_r), .cand(rdata), .arrival(arr_r),
    .found(found), .best_idx(bidx), .best(best)
  );

  assign acc_in    = in_tvalid && in_tready;
  assign in_tready = (st_r == S_IDLE);
  assign fill      = (qty_r < best.qty) ? qty_r : best.qty;
  assign no_cross  = lim_r && ((side_r == 1'b0) ? (lp_r < best.price) : (lp_r > best.price));

  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = SLOTS_PER_SIDE - 1; i >= 0; i--) begin
      if (!vld_r[{side_r, IW'(i)}]) begin
        free_ok  = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    st_nxt = st_r; vld_nxt = vld_r; arr_nxt = arr_r;
    id_nxt = id_r; side_nxt = side_r; lim_nxt = lim_r; lp_nxt = lp_r;
    qty_nxt = qty_r; t_nxt = t_r; cnt_nxt = cnt_r; n_nxt = n_r;
    sv_nxt = 1'b0; si_nxt = si_r;
    ov_nxt = ov_r; od_nxt = od_r; ou_nxt = ou_r;
    rest_nxt = rest_r; drop_nxt = drop_r;
    ctl = '{clear: 1'b0, step: sv_r, side: side_r};
    we = 1'b0; waddr = {~side_r, bidx}; wdata = best;
    raddr = {~side_r, cnt_r[IW-1:0]};
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end
    case (st_r)
      S_IDLE: begin
        if (acc_in) begin
          id_nxt = in_tdata[31:0]; side_nxt = in_tdata[32]; lim_nxt = in_tdata[33];
          lp_nxt = in_tdata[57:34]; qty_nxt = in_tdata[89:58];
          t_nxt = in_tdata[137:90];
          n_nxt = '0; cnt_nxt = '0; rest_nxt = 1'b0; drop_nxt = 1'b0;
          ctl.clear = 1'b1;
          st_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (qty_r == '0 || n_r == CW'(SLOTS_PER_SIDE)) begin
          st_nxt = S_FREE;
        end else if (cnt_r == CW'(SLOTS_PER_SIDE)) begin
          st_nxt = S_DEC;
        end else begin
          sv_nxt = 1'b1; si_nxt = cnt_r[IW-1:0];
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DEC: begin
        // last compare landed on the previous edge; found/best are final here
        st_nxt = S_TRADE;
      end
      S_TRADE: begin
        if (!found || no_cross) begin
          st_nxt = S_FREE;
        end else if (!ov_r || out_tready) begin
          ov_nxt = 1'b1; ou_nxt = KIND_TRADE;
          od_nxt = '0;
          od_nxt[31:0] = best.owner_id; od_nxt[63:32] = id_r;
          od_nxt[87:64] = best.price; od_nxt[119:88] = fill;
          od_nxt[167:120] = t_r; od_nxt[168] = side_r;
          qty_nxt = qty_r - fill;
          we = 1'b1;
          wdata.qty = best.qty - fill;
          if (best.qty == fill) begin
            vld_nxt[{~side_r, bidx}] = 1'b0;
          end
          n_nxt = n_r + 1'b1;
          cnt_nxt = '0; ctl.clear = 1'b1;
          st_nxt = S_SCAN;
        end
      end
      S_FREE: begin
        if (qty_r != '0 && lim_r) begin
          if (free_ok) begin
            we = 1'b1; waddr = {side_r, free_idx};
            wdata = '{owner_id: id_r, price: lp_r, qty: qty_r, seq: arr_r};
            vld_nxt[{side_r, free_idx}] = 1'b1;
            arr_nxt = arr_r + 1'b1;
            rest_nxt = 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
        end
        st_nxt = S_STAT;
      end
      S_STAT: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1; ou_nxt = KIND_STATUS;
          od_nxt = '0;
          od_nxt[63:32] = id_r; od_nxt[167:120] = t_r; od_nxt[168] = side_r;
          od_nxt[169] = rest_r; od_nxt[170] = drop_r; od_nxt[202:171] = qty_r;
          st_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!ov_r || out_tready) begin
          st_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; vld_r <= '0; arr_r <= '0; ov_r <= 1'b0; sv_r <= 1'b0;
      n_r <= '0;
    end else begin
      st_r <= st_nxt; vld_r <= vld_nxt; arr_r <= arr_nxt; ov_r <= ov_nxt;
      sv_r <= sv_nxt; n_r <= n_nxt;
    end
    id_r <= id_nxt; side_r <= side_nxt; lim_r <= lim_nxt; lp_r <= lp_nxt;
    qty_r <= qty_nxt; t_r <= t_nxt; cnt_r <= cnt_nxt;
    si_r <= si_nxt; od_r <= od_nxt; ou_r <= ou_nxt;
    rest_r <= rest_nxt; drop_r <= drop_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;
  assign out_tlast  = ou_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != S_IDLE |-> !in_tready)
    else $error("ready while busy");
  a_trades: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CW'(SLOTS_PER_SIDE))
    else $error("too many fills");
  a_rest: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_STAT |-> !(rest_r && drop_r))
    else $error("rested and dropped together");

endmodule
